[rtl/core/homogeneous_point_transform_core_assert.svh]
// assertion helpers for the point transform core
// both macros expect signals named clk and rst in the calling scope
`ifndef HOMOGENEOUS_POINT_TRANSFORM_CORE_ASSERT_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_CORE_ASSERT_SVH

// same-cycle implication
`define HPT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HPT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/hpt_pkg.sv]
package hpt_pkg;

  localparam int DATA_W   = 32;
  localparam int PROD_W   = 2 * DATA_W;
  localparam int QUO_W    = 32;
  localparam int LANES    = 3;
  localparam int COLS     = 4;
  localparam int NUM_REGS = 8;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 64;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_R0C01 = 3'd0;
  localparam logic [CFG_AW-1:0] REG_R0C23 = 3'd1;
  localparam logic [CFG_AW-1:0] REG_R1C01 = 3'd2;
  localparam logic [CFG_AW-1:0] REG_R1C23 = 3'd3;
  localparam logic [CFG_AW-1:0] REG_R2C01 = 3'd4;
  localparam logic [CFG_AW-1:0] REG_R2C23 = 3'd5;
  localparam logic [CFG_AW-1:0] REG_R3C01 = 3'd6;
  localparam logic [CFG_AW-1:0] REG_R3C23 = 3'd7;

  localparam logic [DATA_W-1:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

endpackage

[rtl/core/hpt_divider.sv]
module hpt_divider
  import hpt_pkg::*;
#(
  parameter int MW        = 50,
  parameter int FRAC_BITS = 16,
  parameter int SBW       = 100
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              ce,
  input  logic              in_vld,
  input  logic [MW-1:0]     in_un [LANES],
  input  logic [MW-1:0]     in_ud,
  input  logic [LANES-1:0]  in_neg,
  input  logic [SBW-1:0]    in_sb,
  output logic              out_vld,
  output logic [QUO_W-1:0]  out_q [LANES],
  output logic [LANES-1:0]  out_ovf,
  output logic [LANES-1:0]  out_neg,
  output logic [SBW-1:0]    out_sb
);

  localparam int SH = QUO_W - FRAC_BITS;

  logic              vld [QUO_W+1];
  logic [MW-1:0]     rem [QUO_W+1][LANES];
  logic [QUO_W-1:0]  nb  [QUO_W+1][LANES];
  logic [QUO_W-1:0]  quo [QUO_W+1][LANES];
  logic [LANES-1:0]  ovf [QUO_W+1];
  logic [LANES-1:0]  neg [QUO_W+1];
  logic [MW-1:0]     ud  [QUO_W+1];
  logic [SBW-1:0]    sb  [QUO_W+1];

  // setup stage: overflow check and first partial remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (ce) begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int l = 0; l < LANES; l++) begin
        ovf[0][l] <= {{SH{1'b0}}, in_un[l]} >= {in_ud, {SH{1'b0}}};
        rem[0][l] <= MW'(in_un[l] >> SH);
        nb[0][l]  <= {in_un[l][SH-1:0], {FRAC_BITS{1'b0}}};
        quo[0][l] <= '0;
      end
      neg[0] <= in_neg;
      ud[0]  <= in_ud;
      sb[0]  <= in_sb;
    end
  end

  // one quotient bit per stage
  for (genvar k = 1; k <= QUO_W; k++) begin : g_step
    logic [MW:0]      t [LANES];
    logic [LANES-1:0] ge;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        t[l]  = {rem[k-1][l], nb[k-1][l][QUO_W-1]};
        ge[l] = t[l] >= {1'b0, ud[k-1]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (ce) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        for (int l = 0; l < LANES; l++) begin
          rem[k][l] <= ge[l] ? MW'(t[l] - {1'b0, ud[k-1]}) : MW'(t[l]);
          quo[k][l] <= {quo[k-1][l][QUO_W-2:0], ge[l]};
          nb[k][l]  <= {nb[k-1][l][QUO_W-2:0], 1'b0};
        end
        ovf[k] <= ovf[k-1];
        neg[k] <= neg[k-1];
        ud[k]  <= ud[k-1];
        sb[k]  <= sb[k-1];
      end
    end
  end

  assign out_vld = vld[QUO_W];
  assign out_q   = quo[QUO_W];
  assign out_ovf = ovf[QUO_W];
  assign out_neg = neg[QUO_W];
  assign out_sb  = sb[QUO_W];

endmodule

[rtl/core/homogeneous_point_transform_core.sv]
// homogeneous 4x4 point transform with perspective divide, signed fixed point
// s_* carries one point (px, py, pz, pw) per request, m_* one transformed
// point (qx, qy, qz) with the divided and saturated flags in m_tuser
// the matrix sits in eight 64-bit registers written through cfg_we /
// cfg_addr / cfg_data, two coefficients per register, column 0 or 2 low
// throughput: one point per cycle while the output does not stall; stages
// from input request to output valid: multiply, row sum, abs/flags, divider
// setup, 32 restoring divider stages at one quotient bit each, saturate/output
// the divider is always in the path, also when w is 0 or 1.0; its result
// is simply not selected then
// reset: clears the pipeline valid bits and loads the identity matrix
// stall: the whole pipeline holds while m_tvalid is high and m_tready low,
// and s_tready drops in that cycle; nothing is lost or repeated
// the matrix may only be rewritten while the pipeline is empty
module homogeneous_point_transform_core
  import hpt_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_AW-1:0]    cfg_addr,
  input  logic [CFG_DW-1:0]    cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [4*DATA_W-1:0]  s_tdata,   // px, py, pz, pw
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [3*DATA_W-1:0]  m_tdata,   // qx, qy, qz
  output logic [1:0]           m_tuser    // divided, saturated
);

  `include "homogeneous_point_transform_core_assert.svh"

  // full-width row sum after dropping the fraction bits
  localparam int SW  = PROD_W + 2 - FRAC_BITS;
  localparam int SBW = 1 + LANES * (DATA_W + 1);
  localparam logic [DATA_W-1:0] ONE = DATA_W'(2 ** FRAC_BITS);

  // matrix registers
  logic [CFG_DW-1:0] cfg_reg [NUM_REGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_REGS; k++) begin
        cfg_reg[k] <= '0;
      end
      cfg_reg[REG_R0C01] <= {{DATA_W{1'b0}}, ONE};
      cfg_reg[REG_R1C01] <= {ONE, {DATA_W{1'b0}}};
      cfg_reg[REG_R2C23] <= {{DATA_W{1'b0}}, ONE};
      cfg_reg[REG_R3C23] <= {ONE, {DATA_W{1'b0}}};
    end else if (cfg_we) begin
      cfg_reg[cfg_addr] <= cfg_data;
    end
  end

  // global advance: the output register is the only place a stall starts
  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // unpack coefficients and point
  logic signed [DATA_W-1:0] coef [COLS][COLS];
  logic signed [DATA_W-1:0] pnt  [COLS];

  always_comb begin
    for (int r = 0; r < COLS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        coef[r][c] = (c % 2 == 1) ? cfg_reg[CFG_AW'(r * 2 + c / 2)][CFG_DW-1:DATA_W]
                                  : cfg_reg[CFG_AW'(r * 2 + c / 2)][DATA_W-1:0];
      end
    end
    for (int c = 0; c < COLS; c++) begin
      pnt[c] = s_tdata[c*DATA_W +: DATA_W];
    end
  end

  // stage 1: sixteen exact products
  logic                     v1;
  logic signed [PROD_W-1:0] prod1 [COLS][COLS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < COLS; r++) begin
        for (int c = 0; c < COLS; c++) begin
          prod1[r][c] <= coef[r][c] * pnt[c];
        end
      end
    end
  end

  // stage 2: row sums, floor to the fixed-point grid
  logic                     v2;
  logic signed [SW-1:0]     sum2 [COLS];
  logic signed [PROD_W+1:0] acc  [COLS];

  always_comb begin
    for (int r = 0; r < COLS; r++) begin
      acc[r] = (PROD_W+2)'(prod1[r][0]) + (PROD_W+2)'(prod1[r][1])
             + (PROD_W+2)'(prod1[r][2]) + (PROD_W+2)'(prod1[r][3]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < COLS; r++) begin
        sum2[r] <= acc[r][PROD_W+1:FRAC_BITS];
      end
    end
  end

  // stage 3: divide decision, magnitudes, and the no-divide result
  logic              v3;
  logic              div3;
  logic [LANES-1:0]  neg3;
  logic [SW-1:0]     un3 [LANES];
  logic [SW-1:0]     ud3;
  logic [DATA_W-1:0] pre3 [LANES];
  logic [LANES-1:0]  psat3;

  logic              div_c;
  logic [SW-1:0]     ud_c;
  logic [LANES-1:0]  neg_c;
  logic [SW-1:0]     un_c  [LANES];
  logic [DATA_W-1:0] pre_c [LANES];
  logic [LANES-1:0]  psat_c;
  logic [SW-DATA_W:0] hi_c [LANES];

  always_comb begin
    div_c = (sum2[3] != '0) && (sum2[3] != SW'(ONE));
    ud_c  = sum2[3][SW-1] ? SW'(-sum2[3]) : SW'(sum2[3]);
    for (int l = 0; l < LANES; l++) begin
      neg_c[l]  = sum2[l][SW-1] ^ sum2[3][SW-1];
      un_c[l]   = sum2[l][SW-1] ? SW'(-sum2[l]) : SW'(sum2[l]);
      // passes only if all bits from the 32-bit sign bit up agree
      hi_c[l]   = sum2[l][SW-1:DATA_W-1];
      psat_c[l] = !((&hi_c[l]) || !(|hi_c[l]));
      if (psat_c[l]) begin
        pre_c[l] = sum2[l][SW-1] ? SAT_MIN : SAT_MAX;
      end else begin
        pre_c[l] = sum2[l][DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div3  <= div_c;
      ud3   <= ud_c;
      neg3  <= neg_c;
      un3   <= un_c;
      pre3  <= pre_c;
      psat3 <= psat_c;
    end
  end

  // divider pipeline, no-divide result rides along as sideband
  logic              dv_vld;
  logic [QUO_W-1:0]  dv_q [LANES];
  logic [LANES-1:0]  dv_ovf;
  logic [LANES-1:0]  dv_neg;
  logic [SBW-1:0]    dv_sb;
  logic [SBW-1:0]    sb3;

  assign sb3 = {div3, psat3, pre3[2], pre3[1], pre3[0]};

  hpt_divider #(
    .MW        (SW),
    .FRAC_BITS (FRAC_BITS),
    .SBW       (SBW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .ce      (adv),
    .in_vld  (v3),
    .in_un   (un3),
    .in_ud   (ud3),
    .in_neg  (neg3),
    .in_sb   (sb3),
    .out_vld (dv_vld),
    .out_q   (dv_q),
    .out_ovf (dv_ovf),
    .out_neg (dv_neg),
    .out_sb  (dv_sb)
  );

  // output stage: sign, saturation and selection
  logic              o_div;
  logic [LANES-1:0]  o_psat;
  logic [DATA_W-1:0] o_pre  [LANES];
  logic [DATA_W-1:0] o_val  [LANES];
  logic [LANES-1:0]  o_dsat;

  always_comb begin
    o_div  = dv_sb[SBW-1];
    o_psat = dv_sb[SBW-2 -: LANES];
    for (int l = 0; l < LANES; l++) begin
      o_pre[l] = dv_sb[l*DATA_W +: DATA_W];
      if (dv_neg[l]) begin
        // magnitude 2^31 still fits as the most negative value
        o_dsat[l] = dv_ovf[l] || (dv_q[l][QUO_W-1] && (|dv_q[l][QUO_W-2:0]));
      end else begin
        o_dsat[l] = dv_ovf[l] || dv_q[l][QUO_W-1];
      end
      if (!o_div) begin
        o_val[l] = o_pre[l];
      end else if (o_dsat[l]) begin
        o_val[l] = dv_neg[l] ? SAT_MIN : SAT_MAX;
      end else begin
        o_val[l] = dv_neg[l] ? DATA_W'(-dv_q[l]) : DATA_W'(dv_q[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata    <= {o_val[2], o_val[1], o_val[0]};
      m_tuser[0] <= o_div;
      m_tuser[1] <= o_div ? (|o_dsat) : (|o_psat);
    end
  end

  // some lane sits on a rail whenever the saturated flag is up
  logic any_rail;
  always_comb begin
    any_rail = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      if (m_tdata[l*DATA_W +: DATA_W] == SAT_MAX || m_tdata[l*DATA_W +: DATA_W] == SAT_MIN) begin
        any_rail = 1'b1;
      end
    end
  end

  `HPT_ASSERT_IMP(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready,
                  "input accepted while output is stalled")
  `HPT_ASSERT_IMP(a_sat_on_rail, m_tvalid && m_tuser[1], any_rail,
                  "saturated flag without a clamped lane")
  `HPT_ASSERT_NXT(a_request_enters, s_tvalid && s_tready, v1,
                  "accepted request missing from first stage")

endmodule

[sim/tb_homogeneous_point_transform_core.sv]
`default_nettype none

module tb_homogeneous_point_transform_core;
  import hpt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam logic [31:0] ONE_FX = 32'h0001_0000;
  // pipeline depth from the core's description, with some margin
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [31:0] x, y, z, w;
  } point_t;

  typedef struct {
    logic [31:0] qx, qy, qz;
    logic        divided, saturated;
  } xform_t;

  // predicts the transformed point from its own copy of the matrix
  class point_scoreboard;
    logic signed [31:0] cf[4][4];
    xform_t pending[$];

    function void load_identity();
      foreach (cf[r, c]) cf[r][c] = (r == c) ? ONE_FX : 32'sd0;
    endfunction

    // a register holds two coefficients of one row, low column in the low half
    function void write_reg(logic [CFG_AW-1:0] idx, logic [63:0] val);
      cf[idx / 2][(idx % 2) * 2]     = val[31:0];
      cf[idx / 2][(idx % 2) * 2 + 1] = val[63:32];
    endfunction

    // exact row sum, floored to the fixed point format
    function logic signed [67:0] row_sum(int r, point_t p);
      logic signed [31:0] pv[4];
      logic signed [63:0] prod;
      logic signed [67:0] acc;
      pv[0] = p.x; pv[1] = p.y; pv[2] = p.z; pv[3] = p.w;
      acc = 0;
      for (int c = 0; c < 4; c++) begin
        prod = cf[r][c] * pv[c];
        acc += prod;
      end
      return acc >>> FRAC;
    endfunction

    // (n << FRAC) / d toward zero, integer part capped at 2^33
    function logic signed [67:0] fx_divide(logic signed [67:0] n, logic signed [67:0] d);
      logic [127:0] un, ud, q, rem;
      logic         neg;
      neg = (n < 0) != (d < 0);
      un = (n < 0) ? 128'(-n) : 128'(n);
      ud = (d < 0) ? 128'(-d) : 128'(d);
      q = un / ud;
      rem = un % ud;
      if (q > 128'h2_0000_0000)
        q = (128'h2_0000_0000 << FRAC) + ((rem << FRAC) / ud);
      else
        q = (un << FRAC) / ud;
      return neg ? -$signed(68'(q)) : $signed(68'(q));
    endfunction

    function logic [31:0] clamp(logic signed [67:0] v, ref logic hit);
      if (v > 68'sh7fff_ffff) begin
        hit = 1'b1;
        return SAT_MAX;
      end
      if (v < -68'sh8000_0000) begin
        hit = 1'b1;
        return SAT_MIN;
      end
      return v[31:0];
    endfunction

    function void note_point(point_t p);
      logic signed [67:0] s[4];
      xform_t e;
      logic   hit;
      for (int r = 0; r < 4; r++) s[r] = row_sum(r, p);
      e.divided = (s[3] != 0) && (s[3] != 68'sh1_0000);
      if (e.divided)
        for (int r = 0; r < 3; r++) s[r] = fx_divide(s[r], s[3]);
      hit = 1'b0;
      e.qx = clamp(s[0], hit);
      e.qy = clamp(s[1], hit);
      e.qz = clamp(s[2], hit);
      e.saturated = hit;
      pending.push_back(e);
    endfunction

    // returns an empty string on a match, else what went wrong
    function string check_result(xform_t got);
      xform_t e;
      if (pending.size() == 0)
        return $sformatf("unexpected result qx=%h qy=%h qz=%h", got.qx, got.qy, got.qz);
      e = pending.pop_front();
      if (got.qx !== e.qx || got.qy !== e.qy || got.qz !== e.qz ||
          got.divided !== e.divided || got.saturated !== e.saturated)
        return $sformatf("got %h %h %h div=%b sat=%b, want %h %h %h div=%b sat=%b",
                         got.qx, got.qy, got.qz, got.divided, got.saturated,
                         e.qx, e.qy, e.qz, e.divided, e.saturated);
      return "";
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CFG_AW-1:0]   cfg_addr;
  logic [CFG_DW-1:0]   cfg_data;
  logic                s_tvalid;
  logic                s_tready;
  logic [4*DATA_W-1:0] s_tdata;   // px, py, pz, pw
  logic                m_tvalid;
  logic                m_tready;
  logic [3*DATA_W-1:0] m_tdata;   // qx, qy, qz
  logic [1:0]          m_tuser;   // divided, saturated

  homogeneous_point_transform_core dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  point_scoreboard board;
  int mismatches = 0;
  int burst_left = 0;
  int cycle_count = 0;
  int stall_mode = 0;

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  initial begin
    #2_000_000;
    $display("homogeneous_point_transform_core: mismatch");
    $finish;
  end

  task automatic report(string what);
    mismatches++;
    $display("error at %0t: %s", $realtime, what);
  endtask

  // receiver: accepted results checked, then the ready pattern moves on
  always @(posedge clk) begin
    xform_t got;
    string  why;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.qx = m_tdata[31:0];
        got.qy = m_tdata[63:32];
        got.qz = m_tdata[95:64];
        got.divided = m_tuser[0];
        got.saturated = m_tuser[1];
        why = board.check_result(got);
        if (why != "") report(why);
      end
      cycle_count++;
      // stall style is redrawn at random from four patterns
      if (cycle_count % 300 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= (cycle_count % 3) != 0;
        2: m_tready <= $urandom_range(0, 1);
        default: m_tready <= (cycle_count % 40) < 8;
      endcase
    end
  end

  // one request; bursts of random length with random gaps between them
  task automatic send_point(point_t p);
    s_tvalid <= 1'b1;
    s_tdata <= {p.w, p.z, p.y, p.x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_point(p);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // matrix rewrites only ever happen with the pipeline empty
  task automatic write_matrix(logic [63:0] regs[8]);
    drain();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= CFG_AW'(i);
      cfg_data <= regs[i];
      @(posedge clk);
      board.write_reg(CFG_AW'(i), regs[i]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coef(int style);
    case (style)
      0: return $urandom;
      1: return $urandom_range(0, 1) ? SAT_MAX : SAT_MIN;
      2: return 32'($signed($urandom_range(0, 8 << FRAC)) - (4 << FRAC));
      default: return $urandom_range(0, 3) == 0 ? ONE_FX : 32'd0;
    endcase
  endfunction

  function automatic point_t rand_point();
    point_t p;
    int     style;
    style = $urandom_range(0, 9);
    p.x = $urandom; p.y = $urandom; p.z = $urandom; p.w = $urandom;
    if (style >= 3) begin
      // moderate coordinates, the usual lattice case
      p.x = 32'($signed($urandom_range(0, 32 << FRAC)) - (16 << FRAC));
      p.y = 32'($signed($urandom_range(0, 32 << FRAC)) - (16 << FRAC));
      p.z = 32'($signed($urandom_range(0, 32 << FRAC)) - (16 << FRAC));
    end
    case (style)
      3, 4, 5: p.w = ONE_FX;
      6: p.w = 32'd0;
      7: p.w = 32'($signed($urandom_range(0, 64)) - 32);
      8: p.w = 32'($signed($urandom_range(0, 8 << FRAC)) - (4 << FRAC));
      default: ;
    endcase
    return p;
  endfunction

  initial begin
    logic [63:0] regs[8];
    point_t      p;
    int          style;
    board = new();
    board.load_identity();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // identity from reset: w alone decides the divide
    send_point('{32'd0, 32'd0, 32'd0, ONE_FX});
    send_point('{SAT_MAX, SAT_MIN, 32'h0001_8000, ONE_FX});
    send_point('{SAT_MIN, SAT_MAX, 32'hffff_ffff, ONE_FX});
    send_point('{32'h0003_0000, 32'hfffd_0000, 32'h0000_0001, 32'd0});
    send_point('{32'h0003_0000, 32'hfffd_0000, 32'h0007_0001, 32'h0002_0000});
    send_point('{32'h0005_0000, 32'hfffb_0000, 32'h0000_0003, 32'hffff_0000});
    // tiny divisor overflows the quotient
    send_point('{SAT_MAX, SAT_MIN, 32'h0000_0010, 32'h0000_0001});
    send_point('{SAT_MIN, SAT_MAX, SAT_MAX, 32'hffff_ffff});
    send_point('{SAT_MAX, SAT_MIN, 32'h1234_5678, SAT_MAX});
    send_point('{SAT_MAX, SAT_MIN, 32'h1234_5678, SAT_MIN});

    // perspective matrix: fourth row picks up z, so w output follows z
    regs = '{64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
             64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
             64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
             64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000};
    write_matrix(regs);
    send_point('{32'h0004_0000, 32'h0002_0000, 32'h0001_0000, 32'd0});
    send_point('{32'h0004_0000, 32'h0002_0000, 32'h0002_0000, 32'd0});
    send_point('{32'h0004_0000, 32'h0002_0000, 32'd0, ONE_FX});
    send_point('{SAT_MAX, SAT_MIN, 32'h0000_0001, 32'd0});
    send_point('{32'hfff0_0000, 32'h0003_0000, 32'hfffe_0000, 32'd0});

    // all coefficients at the extremes: wide sums, capped quotients
    foreach (regs[i]) regs[i] = {SAT_MIN, SAT_MAX};
    write_matrix(regs);
    send_point('{SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX});
    send_point('{SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN});
    send_point('{SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN});
    foreach (regs[i]) regs[i] = {SAT_MIN, SAT_MIN};
    write_matrix(regs);
    send_point('{SAT_MAX, SAT_MIN, 32'd1, 32'hffff_ffff});
    send_point('{SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN});

    // random phases, each under a fresh matrix
    for (int phase = 0; phase < 14; phase++) begin
      style = phase % 4;
      foreach (regs[i]) regs[i] = {rand_coef(style), rand_coef(style)};
      // keep the w row sane at random, never with extreme coefficients, so both branches show up
      if (style != 1 && $urandom_range(0, 1)) begin
        regs[REG_R3C01] = 64'd0;
        regs[REG_R3C23] = {ONE_FX, 32'd0};
      end
      write_matrix(regs);
      repeat (125) send_point(rand_point());
    end

    drain();
    if (mismatches == 0) begin
      $display("homogeneous_point_transform_core: match");
    end else begin
      $display("homogeneous_point_transform_core: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
+incdir+rtl/core
rtl/core/hpt_pkg.sv
rtl/core/hpt_divider.sv
rtl/core/homogeneous_point_transform_core.sv
sim/tb_homogeneous_point_transform_core.sv
